@@ rtl/core/atc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package atc_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int DATA_W = 32;
	localparam int ATAN_LEN = 24;
	localparam int STEP_W = 5;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] DEG_TO_RAD = 32'sd18740330;

	typedef enum logic [2:0] {
		OP_SCALE = 3'd0,
		OP_ROTATE = 3'd1,
		OP_TRANSLATE = 3'd2,
		OP_SHEAR_X = 3'd3,
		OP_SHEAR_Y = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_FOLD,
		ST_ANGLE,
		ST_CORDIC,
		ST_BUILD,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic reduce;
		logic fold;
		logic cordic_start;
		logic cordic_step;
		logic build;
		logic mul_start;
		logic mul_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic is_rotate;
		logic cordic_last;
		logic mul_last;
	} sts_t;

	function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
		logic signed [33:0] r;
		begin
			unique case (i)
				5'd0: r = 34'sd843314857;
				5'd1: r = 34'sd497837829;
				5'd2: r = 34'sd263043837;
				5'd3: r = 34'sd133525159;
				5'd4: r = 34'sd67021687;
				5'd5: r = 34'sd33543516;
				5'd6: r = 34'sd16775851;
				5'd7: r = 34'sd8388437;
				5'd8: r = 34'sd4194283;
				5'd9: r = 34'sd2097149;
				5'd10: r = 34'sd1048576;
				5'd11: r = 34'sd524288;
				5'd12: r = 34'sd262144;
				5'd13: r = 34'sd131072;
				5'd14: r = 34'sd65536;
				5'd15: r = 34'sd32768;
				5'd16: r = 34'sd16384;
				5'd17: r = 34'sd8192;
				5'd18: r = 34'sd4096;
				5'd19: r = 34'sd2048;
				5'd20: r = 34'sd1024;
				5'd21: r = 34'sd512;
				5'd22: r = 34'sd256;
				5'd23: r = 34'sd128;
				default: r = 34'sd0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/atc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module atc_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire atc_pkg::sts_t sts,
	output atc_pkg::cmd_t cmd
);
	atc_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= atc_pkg::ST_IDLE;
		else state_q <= state_next;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			atc_pkg::ST_IDLE: if (in_valid) state_next = atc_pkg::ST_REDUCE;
			atc_pkg::ST_REDUCE: state_next = sts.is_rotate ? atc_pkg::ST_FOLD
				: atc_pkg::ST_BUILD;
			atc_pkg::ST_FOLD: state_next = atc_pkg::ST_ANGLE;
			atc_pkg::ST_ANGLE: state_next = atc_pkg::ST_CORDIC;
			atc_pkg::ST_CORDIC: if (sts.cordic_last) state_next = atc_pkg::ST_BUILD;
			atc_pkg::ST_BUILD: state_next = atc_pkg::ST_MUL;
			atc_pkg::ST_MUL: if (sts.mul_last) state_next = atc_pkg::ST_OUT;
			atc_pkg::ST_OUT: if (!out_stall) state_next = atc_pkg::ST_IDLE;
			default: state_next = atc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			atc_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			atc_pkg::ST_REDUCE: cmd.reduce = 1'b1;
			atc_pkg::ST_FOLD: cmd.fold = 1'b1;
			atc_pkg::ST_ANGLE: cmd.cordic_start = 1'b1;
			atc_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
			atc_pkg::ST_BUILD: begin
				cmd.build = 1'b1;
				cmd.mul_start = 1'b1;
			end
			atc_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				cmd.commit = sts.mul_last;
			end
			atc_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == atc_pkg::ST_OUT) else $error("out valid outside out");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("accept while busy");
	a_commit_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("commit not followed by result");
endmodule
`default_nettype wire

@@ rtl/core/atc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module atc_datapath #(
	parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = atc_pkg::WORD_BITS_DEF,
	parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire atc_pkg::cmd_t cmd,
	output atc_pkg::sts_t sts,
	input wire logic [2:0] op,
	input wire logic restart,
	input wire logic signed [31:0] value_a,
	input wire logic signed [31:0] value_b,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12
);
	localparam int SW = (WORD_BITS < 32) ? WORD_BITS : 32;
	localparam logic signed [63:0] HI = (64'sd1 <<< (SW - 1)) - 64'sd1;
	localparam logic signed [63:0] LO = -HI - 64'sd1;
	localparam int NSTEP = (CORDIC_STEPS < atc_pkg::ATAN_LEN) ? CORDIC_STEPS
		: atc_pkg::ATAN_LEN;
	localparam int CSH = 30 - FRAC_BITS;
	localparam logic signed [63:0] ONE_RAW = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] ONE = (ONE_RAW > HI) ? HI[31:0] : ONE_RAW[31:0];
	localparam int IW = 32 - FRAC_BITS;
	localparam int RW = 36;
	localparam int OFFS = (1 << (IW - 1)) % 360;
	localparam logic [31:0] RECIP = 32'd11930465;
	localparam logic signed [RW-1:0] FULL = 36'sd360 <<< FRAC_BITS;
	localparam logic signed [RW-1:0] HALF = 36'sd180 <<< FRAC_BITS;
	localparam logic signed [RW-1:0] QUART = 36'sd90 <<< FRAC_BITS;

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		logic signed [31:0] r;
		begin
			if (v > HI) r = HI[31:0];
			else if (v < LO) r = LO[31:0];
			else r = v[31:0];
			return r;
		end
	endfunction

	logic [2:0] op_q;
	logic signed [31:0] a_q, b_q;
	logic signed [31:0] acc_q [6];
	logic signed [31:0] s_q [6];
	logic [15:0] q_q;
	logic flip_q;
	logic signed [31:0] r_q;
	logic signed [33:0] x_q, y_q, z_q;
	logic [atc_pkg::STEP_W-1:0] it_q;
	logic [2:0] mi_q;
	logic signed [31:0] nm_q [6];

	logic [IW-1:0] ang_u;
	logic [63:0] ang_prod;
	logic [8:0] ang_rem;
	logic signed [9:0] ang_int;
	logic signed [RW-1:0] r0, r1, r2;
	logic rflip;
	logic signed [63:0] zp;
	logic signed [63:0] xr, yr, cs, sn;
	logic signed [31:0] s_d [6];
	logic rr;
	logic [2:0] jj, ja, is0, is1, is2;

	assign sts.is_rotate = op_q == atc_pkg::OP_ROTATE;
	assign sts.cordic_last = it_q == atc_pkg::STEP_W'(NSTEP - 1);
	assign sts.mul_last = mi_q == 3'd5;

	// angle mod 360 on the biased integer part, reciprocal quotient
	always_comb begin
		ang_u = {~a_q[31], a_q[30:FRAC_BITS]};
		ang_prod = 64'(ang_u) * 64'(RECIP);
		ang_rem = 9'(32'(ang_u) - 32'(q_q) * 32'd360);
		ang_int = $signed({1'b0, ang_rem}) - 10'(OFFS);
		r0 = (RW'(ang_int) <<< FRAC_BITS) + $signed(RW'(a_q[FRAC_BITS-1:0]));
		r1 = r0;
		if (r0 >= HALF) r1 = r0 - FULL;
		else if (r0 < -HALF) r1 = r0 + FULL;
		r2 = r1;
		rflip = 1'b0;
		if (r1 > QUART) begin
			r2 = r1 - HALF;
			rflip = 1'b1;
		end else if (r1 < -QUART) begin
			r2 = r1 + HALF;
			rflip = 1'b1;
		end
		zp = (64'(r_q) * 64'(atc_pkg::DEG_TO_RAD) + (64'sd1 <<< (FRAC_BITS - 1)))
			>>> FRAC_BITS;
		xr = (64'(x_q) + (64'sd1 <<< (CSH - 1))) >>> CSH;
		yr = (64'(y_q) + (64'sd1 <<< (CSH - 1))) >>> CSH;
		cs = flip_q ? -xr : xr;
		sn = flip_q ? -yr : yr;
	end

	always_comb begin
		s_d[0] = ONE; s_d[1] = '0; s_d[2] = '0;
		s_d[3] = '0; s_d[4] = ONE; s_d[5] = '0;
		unique case (op_q)
			atc_pkg::OP_SCALE: begin
				s_d[0] = a_q; s_d[4] = b_q;
			end
			atc_pkg::OP_ROTATE: begin
				s_d[0] = sat(cs); s_d[1] = sat(-64'(sat(sn)));
				s_d[3] = sat(sn); s_d[4] = sat(cs);
			end
			atc_pkg::OP_TRANSLATE: begin
				s_d[2] = a_q; s_d[5] = b_q;
			end
			atc_pkg::OP_SHEAR_X: s_d[1] = a_q;
			atc_pkg::OP_SHEAR_Y: s_d[3] = a_q;
			default: ;
		endcase
	end

	// product for entry mi = r*3+j, one entry per cycle
	logic signed [63:0] p0, p1, pv;
	always_comb begin
		rr = mi_q >= 3'd3;
		jj = rr ? mi_q - 3'd3 : mi_q;
		ja = jj + 3'd3;
		is0 = rr ? 3'd3 : 3'd0;
		is1 = rr ? 3'd4 : 3'd1;
		is2 = rr ? 3'd5 : 3'd2;
		p0 = (64'(s_q[is0]) * 64'(acc_q[jj]) + (64'sd1 <<< (FRAC_BITS - 1)))
			>>> FRAC_BITS;
		p1 = (64'(s_q[is1]) * 64'(acc_q[ja]) + (64'sd1 <<< (FRAC_BITS - 1)))
			>>> FRAC_BITS;
		pv = p0 + p1 + ((jj == 3'd2) ? 64'(s_q[is2]) : 64'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0] <= ONE; acc_q[1] <= '0; acc_q[2] <= '0;
			acc_q[3] <= '0; acc_q[4] <= ONE; acc_q[5] <= '0;
		end else if (cmd.load && restart) begin
			acc_q[0] <= ONE; acc_q[1] <= '0; acc_q[2] <= '0;
			acc_q[3] <= '0; acc_q[4] <= ONE; acc_q[5] <= '0;
		end else if (cmd.commit) begin
			acc_q[0] <= nm_q[0]; acc_q[1] <= nm_q[1]; acc_q[2] <= nm_q[2];
			acc_q[3] <= nm_q[3]; acc_q[4] <= nm_q[4];
			acc_q[5] <= sat(pv);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			a_q <= sat(64'(value_a));
			b_q <= sat(64'(value_b));
		end
		if (cmd.reduce) q_q <= 16'(ang_prod >> 32);
		if (cmd.fold) begin
			r_q <= 32'(r2);
			flip_q <= rflip;
		end
		if (cmd.cordic_start) begin
			it_q <= '0;
			x_q <= atc_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= 34'(zp);
		end else if (cmd.cordic_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - (y_q >>> it_q);
				y_q <= y_q + (x_q >>> it_q);
				z_q <= z_q - atc_pkg::atan_q30(it_q);
			end else begin
				x_q <= x_q + (y_q >>> it_q);
				y_q <= y_q - (x_q >>> it_q);
				z_q <= z_q + atc_pkg::atan_q30(it_q);
			end
			it_q <= it_q + atc_pkg::STEP_W'(1);
		end
		if (cmd.build) s_q <= s_d;
		if (cmd.mul_start) mi_q <= '0;
		else if (cmd.mul_step) begin
			nm_q[mi_q] <= sat(pv);
			mi_q <= mi_q + 3'd1;
		end
	end

	assign m00 = acc_q[0];
	assign m01 = acc_q[1];
	assign m02 = acc_q[2];
	assign m10 = acc_q[3];
	assign m11 = acc_q[4];
	assign m12 = acc_q[5];
endmodule
`default_nettype wire

@@ rtl/core/affine_transform_composer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One transform step per item, one item at a time. A rotate step passes through the
// extra angle fold and angle conversion states and runs CORDIC_STEPS iterations (at
// most 24) of iterative CORDIC. The six matrix entries are formed one per cycle on a
// shared pair of multipliers. An output stall holds the result; the next item is
// taken after the result is delivered.
module affine_transform_composer #(
	parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = atc_pkg::WORD_BITS_DEF,
	parameter int CORDIC_STEPS = atc_pkg::CORDIC_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] op,
	input wire logic restart,
	input wire logic signed [31:0] value_a,
	input wire logic signed [31:0] value_b,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12
);
	atc_pkg::cmd_t cmd;
	atc_pkg::sts_t sts;

	atc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	atc_datapath #(
		.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .op(op),
		.restart(restart), .value_a(value_a), .value_b(value_b),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12)
	);
endmodule
`default_nettype wire

@@ test/affine_transform_composer_tb.sv @@
`timescale 1ns / 1ps
module affine_transform_composer_tb;
	typedef struct {
		logic [2:0] op;
		logic restart;
		logic signed [31:0] a;
		logic signed [31:0] b;
		int gap;
	} step_item_t;

	typedef struct {
		logic signed [31:0] e [6];
	} matrix_t;

	localparam int FRAC = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] op = '0;
	logic restart = 1'b0;
	logic signed [31:0] value_a = '0;
	logic signed [31:0] value_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] m00, m01, m02, m10, m11, m12;

	step_item_t pending_steps [$];
	matrix_t expected_matrices [$];
	longint running [6];
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit driving = 1'b0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	affine_transform_composer i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.op(op), .restart(restart), .value_a(value_a), .value_b(value_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12)
	);

	always #5 clk = ~clk;

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint rshift(longint v, int n);
		return fshift(v + (longint'(1) <<< (n - 1)), n);
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint atan_entry(int i);
		longint t [16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
			262144, 131072, 65536, 32768};
		return t[i];
	endfunction

	task automatic trig(input longint deg, output longint cs, output longint sn);
		longint full, half, quarter, r, x, y, z, dx, dy;
		bit flip;
		full = longint'(360) <<< FRAC;
		half = longint'(180) <<< FRAC;
		quarter = longint'(90) <<< FRAC;
		r = deg % full;
		flip = 1'b0;
		x = 652032874;
		y = 0;
		if (r >= half)
			r -= full;
		else if (r < -half)
			r += full;
		if (r > quarter) begin
			r -= half;
			flip = 1'b1;
		end else if (r < -quarter) begin
			r += half;
			flip = 1'b1;
		end
		z = rshift(r * 18740330, FRAC);
		for (int i = 0; i < 16; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		x = rshift(x, 30 - FRAC);
		y = rshift(y, 30 - FRAC);
		if (flip) begin
			x = -x;
			y = -y;
		end
		cs = clip32(x);
		sn = clip32(y);
	endtask

	task automatic load_unit(ref longint m [6]);
		m = '{longint'(1) <<< FRAC, 0, 0, 0, longint'(1) <<< FRAC, 0};
	endtask

	task automatic compose_step(input step_item_t it);
		longint s [6], nm [6], cs, sn, a, b, v;
		matrix_t res;
		a = longint'(it.a);
		b = longint'(it.b);
		if (it.restart)
			load_unit(running);
		load_unit(s);
		unique case (it.op)
			atc_pkg::OP_SCALE: begin
				s[0] = a; s[4] = b;
			end
			atc_pkg::OP_ROTATE: begin
				trig(a, cs, sn);
				s[0] = cs; s[1] = clip32(-sn); s[3] = sn; s[4] = cs;
			end
			atc_pkg::OP_TRANSLATE: begin
				s[2] = a; s[5] = b;
			end
			atc_pkg::OP_SHEAR_X: s[1] = a;
			atc_pkg::OP_SHEAR_Y: s[3] = a;
			default: ;
		endcase
		for (int r = 0; r < 2; r++)
			for (int j = 0; j < 3; j++) begin
				v = rshift(s[r*3] * running[j], FRAC)
					+ rshift(s[r*3+1] * running[3+j], FRAC);
				if (j == 2)
					v += s[r*3+2];
				nm[r*3+j] = clip32(v);
			end
		for (int j = 0; j < 6; j++) begin
			running[j] = nm[j];
			res.e[j] = nm[j][31:0];
		end
		expected_matrices = {expected_matrices, res};
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			2: return $signed($urandom_range(0, 720 << 16)) - (360 << 16);
			3: return ($urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000);
			default: return $signed($urandom_range(0, 3 << 16)) - (3 << 15);
		endcase
	endfunction

	task automatic add_step(input logic [2:0] o, input logic rs,
		input logic signed [31:0] a, input logic signed [31:0] b);
		step_item_t it;
		it.op = o;
		it.restart = rs;
		it.a = a;
		it.b = b;
		it.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		pending_steps = {pending_steps, it};
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				compose_step(step_item_t'{op, restart, value_a, value_b, 0});
				driving = 1'b0;
			end
			if (!driving || (in_valid && !in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_steps.size() > 0 && !hold_off) begin
					step_item_t it;
					it = pending_steps.pop_front();
					if (it.gap > 0 && in_valid && !in_stall) begin
						pending_steps.push_front(it);
						gap_left = it.gap - 1;
						pending_steps[0].gap = 0;
						in_valid <= 1'b0;
					end else if (it.gap > 0 && !in_valid) begin
						pending_steps.push_front(it);
						gap_left = it.gap - 1;
						pending_steps[0].gap = 0;
					end else begin
						op <= it.op;
						restart <= it.restart;
						value_a <= it.a;
						value_b <= it.b;
						in_valid <= 1'b1;
						driving = 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			logic signed [31:0] got [6];
			matrix_t ex;
			got = '{m00, m01, m02, m10, m11, m12};
			if (expected_matrices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h %h %h %h %h %h",
						m00, m01, m02, m10, m11, m12);
			end else begin
				ex = expected_matrices.pop_front();
				for (int j = 0; j < 6; j++)
					if (got[j] !== ex.e[j]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("entry %0d: expected %h got %h", j, ex.e[j], got[j]);
					end
			end
			stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		load_unit(running);
		add_step(atc_pkg::OP_SCALE, 1'b0, 32'sh00020000, 32'sh00008000);
		add_step(atc_pkg::OP_ROTATE, 1'b0, 32'sh005a0000, 32'sh12345678);
		add_step(atc_pkg::OP_TRANSLATE, 1'b0, 32'sh7fffffff, 32'sh80000000);
		add_step(atc_pkg::OP_SHEAR_X, 1'b0, 32'sh00010000, '0);
		add_step(atc_pkg::OP_SHEAR_Y, 1'b0, 32'shffff0000, '1);
		add_step(3'd5, 1'b0, '1, '1);
		add_step(3'd6, 1'b1, '0, '0);
		add_step(3'd7, 1'b0, '0, '0);
		add_step(atc_pkg::OP_ROTATE, 1'b1, 32'sh00b40000, '0);
		add_step(atc_pkg::OP_ROTATE, 1'b0, 32'shff4c0000, '0);
		add_step(atc_pkg::OP_ROTATE, 1'b0, 32'sh7fffffff, '0);
		add_step(atc_pkg::OP_ROTATE, 1'b0, 32'sh80000000, '0);
		add_step(atc_pkg::OP_ROTATE, 1'b0, 32'sh01680000, '0);
		add_step(atc_pkg::OP_ROTATE, 1'b0, 32'shffa60000, '0);
		add_step(atc_pkg::OP_SCALE, 1'b1, 32'sh7fffffff, 32'sh7fffffff);
		add_step(atc_pkg::OP_SCALE, 1'b0, 32'sh7fffffff, 32'sh80000000);
		add_step(atc_pkg::OP_TRANSLATE, 1'b0, 32'sh7fffffff, 32'sh7fffffff);
		add_step(atc_pkg::OP_SHEAR_X, 1'b1, 32'sh80000000, '0);
		add_step(atc_pkg::OP_SHEAR_Y, 1'b0, 32'sh7fffffff, '0);
		add_step(atc_pkg::OP_SCALE, 1'b1, '0, '0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_steps.size() == 0 && !in_valid);
		hold_off = 1'b1;
		wait (expected_matrices.size() == 0);
		@(posedge clk);
		hold_off = 1'b0;
		for (int n = 0; n < 1500; n++) begin
			int r;
			r = $urandom_range(0, 19);
			add_step(r < 18 ? 3'(r % 5) : 3'($urandom_range(5, 7)),
				$urandom_range(0, 7) == 0, rand_value(), rand_value());
		end
		wait (pending_steps.size() == 0 && !in_valid);
		wait (expected_matrices.size() == 0);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && expected_matrices.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

@@ sim.f @@
rtl/core/atc_pkg.sv
rtl/core/atc_ctrl.sv
rtl/core/atc_datapath.sv
rtl/core/affine_transform_composer.sv
test/affine_transform_composer_tb.sv
